// ----- hdl/nzcs_pkg.sv -----
// nzcs_pkg: shared constants and types for the nearest zero-crossing search
// no dependencies; imported by the top level

package nzcs_pkg;

   // configuration port geometry
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // fixed field widths of the configuration registers
   localparam int RADIUS_BITS = 16;
   localparam int COUNT_BITS  = 21;

   // register reset values
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd256;
   localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = 21'd0;

   // register index, taken from address bit 2
   typedef enum logic {
      CSR_RADIUS = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_index_type;

endpackage

// ----- hdl/nzcs_req_if.sv -----
// nzcs_req_if: sample channel (valid/ready) carrying one audio sample a beat
// no dependencies

interface nzcs_req_if #(
   parameter int INDEX_BITS  = 20,
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic        [INDEX_BITS-1:0]  target_index;
   logic                          first_of_buffer;

   modport source (output valid, output sample_value, output target_index,
                   output first_of_buffer, input ready);
   modport sink   (input valid, input sample_value, input target_index,
                   input first_of_buffer, output ready);
endinterface

// ----- hdl/nzcs_rsp_if.sv -----
// nzcs_rsp_if: result channel (valid/ready) carrying one snapped index a beat
// no dependencies

interface nzcs_rsp_if #(
   parameter int INDEX_BITS = 20
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] snapped_index;
   logic                  crossing_found;

   modport source (output valid, output snapped_index, output crossing_found,
                   input ready);
   modport sink   (input valid, input snapped_index, input crossing_found,
                   output ready);
endinterface

// ----- hdl/nearest_zero_crossing_search.sv -----
// nearest_zero_crossing_search: streaming zero-crossing snap over one buffer
// depends on nzcs_pkg, nzcs_req_if and nzcs_rsp_if
//
// Usage
//   req carries one sample a beat in buffer order; the beat with
//   first_of_buffer set is sample zero and brings the target index.
//   rsp gives one beat per buffer, on the beat of the last sample: the
//   chosen index and whether a real sign crossing was found. A buffer of
//   sample_count 0 or 1 answers on its first beat with the raw target.
//   csr is an APB-style port: search_radius at 0x0, sample_count at 0x4,
//   both taken at the first sample of a buffer.
// Pipeline and throughput
//   a beat is held in the input register, then evaluated against the
//   kept search state into the result register, where the result of
//   the last sample of a buffer becomes valid.
//   One sample per cycle is taken unless a result-giving sample waits;
//   the per-sample compares against the search registers set that rate.
// Reset and stall
//   synchronous reset empties both registers, drops any search in progress
//   and restores search_radius 256 and sample_count 0. While a result waits
//   on rsp, samples that give no result still flow; only a sample that
//   would give a second result waits in the input register.

module nearest_zero_crossing_search #(
   parameter int INDEX_BITS  = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   nzcs_req_if.sink                              req,
   nzcs_rsp_if.source                            rsp,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [nzcs_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [nzcs_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [nzcs_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import nzcs_pkg::*;

   localparam int IB = INDEX_BITS;
   localparam int SB = SAMPLE_BITS;
   localparam int MB = SB + 1;                       // exact magnitude width
   localparam int WW = ((IB > 20) ? IB : 20) + 2;    // window arithmetic width
   localparam logic [MB-1:0] MAG_SENTINEL = (MB'(1) << (SB - 1)) + MB'(1);

   // exact magnitude of a signed sample
   function automatic logic [MB-1:0] mag_of(input logic signed [SB-1:0] v);
      logic [MB-1:0] e;
      e = MB'(unsigned'(v));
      if (v[SB-1]) begin
         e = {1'b1, v};
         e = ~e + MB'(1);
      end
      return e;
   endfunction

   // configuration registers
   logic [RADIUS_BITS-1:0] radius_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic                   csr_write;
   csr_index_type          csr_index;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         CSR_RADIUS: csr_prdata = CSR_DATA_BITS'(radius_ff);
         CSR_COUNT:  csr_prdata = CSR_DATA_BITS'(count_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= csr_pwdata[RADIUS_BITS-1:0];
            CSR_COUNT:  count_ff  <= csr_pwdata[COUNT_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // window set-up for a first-of-buffer beat, ahead of the input register
   logic [WW-1:0] n_raw, n_cap, cap_w, ct_w, r_w, sum_w, lim_w;
   logic [IB-1:0] pre_last, pre_ct, pre_lo, pre_hi;
   logic          pre_short;

   always_comb begin
      n_raw     = WW'(count_ff);
      cap_w     = WW'(1) << IB;
      n_cap     = (n_raw > cap_w) ? cap_w : n_raw;
      pre_short = (n_cap <= WW'(1));
      pre_last  = IB'(n_cap - WW'(1));
      pre_ct    = (req.target_index < pre_last) ? req.target_index : pre_last;
      ct_w      = WW'(pre_ct);
      r_w       = WW'(radius_ff);
      pre_lo    = (ct_w >= r_w) ? IB'(ct_w - r_w) : '0;
      sum_w     = ct_w + r_w;
      lim_w     = n_cap - WW'(2);
      pre_hi    = (sum_w < lim_w) ? IB'(sum_w) : IB'(lim_w);
   end

   // input register
   logic                 s1_valid_ff;
   logic signed [SB-1:0] s1_sample_ff;
   logic [IB-1:0]        s1_target_ff;
   logic                 s1_first_ff;
   logic                 s1_short_ff;
   logic [IB-1:0]        s1_ct_ff, s1_lo_ff, s1_hi_ff, s1_last_ff;
   logic                 s1_valid_in;
   logic                 s1_load;
   logic                 s2_take;

   assign req.ready   = !s1_valid_ff || s2_take;
   assign s1_load     = req.valid && req.ready;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sample_ff <= req.sample_value;
         s1_target_ff <= req.target_index;
         s1_first_ff  <= req.first_of_buffer;
         s1_short_ff  <= pre_short;
         s1_ct_ff     <= pre_ct;
         s1_lo_ff     <= pre_lo;
         s1_hi_ff     <= pre_hi;
         s1_last_ff   <= pre_last;
      end
   end

   // search state
   logic                 busy_ff,  busy_in;
   logic signed [SB-1:0] prev_ff,  prev_in;
   logic [IB-1:0]        pos_ff,   pos_in;
   logic [IB-1:0]        ct_ff,    ct_in;
   logic [IB-1:0]        lo_ff,    lo_in;
   logic [IB-1:0]        hi_ff,    hi_in;
   logic [IB-1:0]        last_ff,  last_in;
   logic                 found_ff, found_in;
   logic [IB-1:0]        bestd_ff, bestd_in;
   logic [IB-1:0]        bestx_ff, bestx_in;
   logic [MB-1:0]        leastm_ff, leastm_in;
   logic [IB-1:0]        leasti_ff, leasti_in;

   // per-sample evaluation
   logic [IB-1:0] p, s, d;
   logic [IB:0]   p_w, hi_plus;
   logic [MB-1:0] mag_v, mag_a;
   logic          is_cross, in_cross_win, in_least_win;
   logic          emit;
   logic [IB-1:0] res_index;
   logic          res_found;

   always_comb begin
      p            = pos_ff + IB'(1);
      s            = pos_ff;
      p_w          = {1'b0, p};
      hi_plus      = {1'b0, hi_ff} + (IB+1)'(1);
      mag_v        = mag_of(s1_sample_ff);
      mag_a        = mag_of(prev_ff);
      is_cross     = ((prev_ff <= 0) && (s1_sample_ff >= 0)) ||
                     ((prev_ff >= 0) && (s1_sample_ff <= 0));
      in_cross_win = (s >= lo_ff) && (s <= hi_ff);
      in_least_win = (p >= lo_ff) && (p_w <= hi_plus);
      d            = (s >= ct_ff) ? (s - ct_ff) : (ct_ff - s);

      busy_in   = busy_ff;
      prev_in   = prev_ff;
      pos_in    = pos_ff;
      ct_in     = ct_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      last_in   = last_ff;
      found_in  = found_ff;
      bestd_in  = bestd_ff;
      bestx_in  = bestx_ff;
      leastm_in = leastm_ff;
      leasti_in = leasti_ff;
      emit      = 1'b0;
      res_index = '0;
      res_found = 1'b0;

      if (s1_valid_ff) begin
         if (s1_first_ff) begin
            if (s1_short_ff) begin
               // buffer too short to search: hand back the raw target
               busy_in   = 1'b0;
               emit      = 1'b1;
               res_index = s1_target_ff;
            end else begin
               // open a new search at sample zero
               busy_in  = 1'b1;
               ct_in    = s1_ct_ff;
               lo_in    = s1_lo_ff;
               hi_in    = s1_hi_ff;
               last_in  = s1_last_ff;
               found_in = 1'b0;
               bestd_in = '1;
               bestx_in = '0;
               prev_in  = s1_sample_ff;
               pos_in   = '0;
               if (s1_lo_ff == '0) begin
                  leastm_in = mag_v;
                  leasti_in = '0;
               end else begin
                  leastm_in = MAG_SENTINEL;
                  leasti_in = s1_ct_ff;
               end
            end
         end else if (busy_ff) begin
            // crossing between previous and current sample
            if (in_cross_win && is_cross && (!found_ff || (d < bestd_ff))) begin
               bestd_in = d;
               bestx_in = (mag_a < mag_v) ? s : p;
               found_in = 1'b1;
            end
            // least-magnitude fallback
            if (in_least_win && (mag_v < leastm_ff)) begin
               leastm_in = mag_v;
               leasti_in = p;
            end
            prev_in = s1_sample_ff;
            pos_in  = p;
            if (p == last_ff) begin
               busy_in   = 1'b0;
               emit      = 1'b1;
               res_found = found_in;
               res_index = found_in ? bestx_in : leasti_in;
            end
         end
      end
   end

   // the beat leaves the input register unless its result has nowhere to go
   assign s2_take = s1_valid_ff && (!emit || !rsp.valid || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else if (s2_take) begin
         busy_ff  <= busy_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         prev_ff   <= prev_in;
         pos_ff    <= pos_in;
         ct_ff     <= ct_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         last_ff   <= last_in;
         bestd_ff  <= bestd_in;
         bestx_ff  <= bestx_in;
         leastm_ff <= leastm_in;
         leasti_ff <= leasti_in;
      end
   end

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IB-1:0] rsp_index_ff;
   logic          rsp_found_ff;
   logic          rsp_load;

   assign rsp_load     = s2_take && emit;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= res_index;
         rsp_found_ff <= res_found;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.snapped_index  = rsp_index_ff;
   assign rsp.crossing_found = rsp_found_ff;

`ifndef NO_ASSERTIONS
   // a running search never walks past its last index
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < last_ff))
      else $error("search position beyond last index");

   // a recorded crossing lies inside the window or one sample past it
   a_crossing_in_window: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && found_ff) |-> ((bestx_ff >= lo_ff) && ({1'b0, bestx_ff} <= hi_plus)))
      else $error("recorded crossing outside search window");

   // a mid-buffer result only comes out of a running search
   a_emit_needs_search: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !s1_first_ff) |-> busy_ff)
      else $error("result produced with no search running");

   // a held beat is not dropped from the input register
   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_take) |=> (s1_valid_ff && $stable(s1_sample_ff)))
      else $error("stalled beat lost from input register");
`endif

endmodule
